// ----- rtl/core/utft_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF transcoder package
// Shared types, format codes and the byte-level encoding functions used by
// the front end, the job queue and the byte emitter.
// ----------------------------------------------------------------------------
package utft_pkg;

    // Format codes, shared by the source and target format registers.
    localparam logic [2:0] FMT_UTF8     = 3'd0;
    localparam logic [2:0] FMT_UTF8_BOM = 3'd1;
    localparam logic [2:0] FMT_UTF16LE  = 3'd2;
    localparam logic [2:0] FMT_UTF16BE  = 3'd3;
    localparam logic [2:0] FMT_UTF32LE  = 3'd4;
    localparam logic [2:0] FMT_UTF32BE  = 3'd5;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_FORMAT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FORMAT = 1'd1;

    localparam int CP_W = 21;

    localparam logic [15:0]     REPL_UNIT  = 16'hFFFD;
    localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
    localparam logic [15:0]     SURR_LEAD  = 16'hD800;
    localparam logic [15:0]     SURR_TRAIL = 16'hDC00;
    localparam logic [CP_W-1:0] SUPP_BASE  = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;

    // Job queue between the front end and the byte emitter.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CP_W-1:0] cp_t;

    typedef struct packed {
        logic       stream_end;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    // One transaction's worth of output work: an optional target BOM followed
    // by up to two code points.
    typedef struct packed {
        logic bom;
        logic cp0_valid;
        logic cp1_valid;
        cp_t  cp0;
        cp_t  cp1;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_head_t;

    typedef struct packed {
        logic bom_sent;
        logic unit_pending;
        logic lead_pending;
    } front_status_t;

    function automatic logic [2:0] fmt_of(input logic [2:0] f);
        return (f > FMT_UTF32BE) ? FMT_UTF8 : f;
    endfunction

    function automatic logic [2:0] bom_len(input logic [2:0] f);
        logic [2:0] len;
        case (fmt_of(f))
            FMT_UTF8_BOM:             len = 3'd3;
            FMT_UTF16LE, FMT_UTF16BE: len = 3'd2;
            FMT_UTF32LE, FMT_UTF32BE: len = 3'd4;
            default:                  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] bom_byte(input logic [2:0] f, input logic [1:0] idx);
        logic [31:0] seq;
        case (fmt_of(f))
            FMT_UTF8_BOM: seq = 32'hEF_BB_BF_00;
            FMT_UTF16LE:  seq = 32'hFF_FE_00_00;
            FMT_UTF16BE:  seq = 32'hFE_FF_00_00;
            FMT_UTF32LE:  seq = 32'hFF_FE_00_00;
            FMT_UTF32BE:  seq = 32'h00_00_FE_FF;
            default:      seq = 32'h00_00_00_00;
        endcase
        return seq[8*(3 - int'(idx)) +: 8];
    endfunction

    // UTF-16 code units of a code point: {first unit, second unit}.
    function automatic logic [31:0] utf16_units(input cp_t cp);
        logic [19:0] v;
        logic [31:0] units;
        v = 20'(cp - SUPP_BASE);
        if (cp < SUPP_BASE) begin
            units = {cp[15:0], 16'h0000};
        end
        else if (cp > CP_MAX) begin
            units = {REPL_UNIT, 16'h0000};
        end
        else begin
            units = {SURR_LEAD | {6'd0, v[19:10]}, SURR_TRAIL | {6'd0, v[9:0]}};
        end
        return units;
    endfunction

    function automatic logic [2:0] enc_len(input logic [2:0] f, input cp_t cp);
        logic [2:0] len;
        case (fmt_of(f))
            FMT_UTF16LE, FMT_UTF16BE: begin
                len = (cp < SUPP_BASE || cp > CP_MAX) ? 3'd2 : 3'd4;
            end
            FMT_UTF32LE, FMT_UTF32BE: len = 3'd4;
            default: begin
                if (cp <= 21'h00007F) begin
                    len = 3'd1;
                end
                else if (cp <= 21'h0007FF) begin
                    len = 3'd2;
                end
                else if (cp <= 21'h00FFFF) begin
                    len = 3'd3;
                end
                else begin
                    len = 3'd4;
                end
            end
        endcase
        return len;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [2:0] f, input cp_t cp,
                                            input logic [1:0] idx);
        logic [31:0] units;
        logic [15:0] unit;
        logic [31:0] word;
        logic [2:0]  len;
        logic [7:0]  b;
        units = utf16_units(cp);
        unit  = idx[1] ? units[15:0] : units[31:16];
        word  = {11'd0, cp};
        len   = enc_len(f, cp);
        case (fmt_of(f))
            FMT_UTF16LE: b = idx[0] ? unit[15:8] : unit[7:0];
            FMT_UTF16BE: b = idx[0] ? unit[7:0] : unit[15:8];
            FMT_UTF32LE: b = word[8*int'(idx) +: 8];
            FMT_UTF32BE: b = word[8*(3 - int'(idx)) +: 8];
            default: begin
                case (len)
                    3'd1: b = {1'b0, cp[6:0]};
                    3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
                    3'd3: begin
                        case (idx)
                            2'd0:    b = {4'b1110, cp[15:12]};
                            2'd1:    b = {2'b10, cp[11:6]};
                            default: b = {2'b10, cp[5:0]};
                        endcase
                    end
                    default: begin
                        case (idx)
                            2'd0:    b = {5'b11110, cp[20:18]};
                            2'd1:    b = {2'b10, cp[17:12]};
                            2'd2:    b = {2'b10, cp[11:6]};
                            default: b = {2'b10, cp[5:0]};
                        endcase
                    end
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/core/utft_front.sv -----
// ----------------------------------------------------------------------------
// UTF transcoder front end
// Holds the format registers and the decoder state, takes one source byte
// per transaction and pushes a job when it finishes a code point or owes the target BOM.
// ----------------------------------------------------------------------------
module utft_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  utft_pkg::in_item_t     in_data,
    input  utft_pkg::cfg_write_t   cfg,
    input  logic                   queue_full,
    output utft_pkg::queue_push_t  push,
    output logic [2:0]             target_format,
    output utft_pkg::front_status_t status
);
    import utft_pkg::*;

    logic [2:0]  source_format_reg, source_format_next;
    logic [2:0]  target_format_reg, target_format_next;
    cp_t         acc_reg, acc_next;
    logic [2:0]  pend_reg, pend_next;
    logic [10:0] lead_reg, lead_next;
    logic [2:0]  bom_left_reg, bom_left_next;
    logic        bom_sent_reg, bom_sent_next;

    logic        accept;
    job_t        job;

    always_comb begin
        logic [2:0]  f;
        logic [7:0]  b;
        logic [15:0] u;
        cp_t         acc8;
        cp_t         acc32;

        source_format_next = source_format_reg;
        target_format_next = target_format_reg;
        acc_next           = acc_reg;
        pend_next          = pend_reg;
        lead_next          = lead_reg;
        bom_left_next      = bom_left_reg;
        bom_sent_next      = bom_sent_reg;
        job                = '0;

        f      = fmt_of(source_format_reg);
        b      = in_data.data_byte;
        u      = (f == FMT_UTF16BE) ? {acc_reg[7:0], b} : {b, acc_reg[7:0]};
        acc8   = {acc_reg[14:0], b[5:0]};
        acc32  = (f == FMT_UTF32BE) ? {acc_reg[12:0], b}
                                    : acc_reg | (cp_t'(b) << {pend_reg[1:0], 3'b000});
        accept = in_valid && !queue_full;

        if (accept) begin
            if (!bom_sent_reg) begin
                job.bom       = (bom_len(target_format_reg) != 3'd0);
                bom_sent_next = 1'b1;
            end

            if (in_data.stream_end) begin
                acc_next      = '0;
                pend_next     = '0;
                lead_next     = '0;
                bom_left_next = bom_len(source_format_reg);
                bom_sent_next = 1'b0;
            end
            else if (bom_left_reg != 3'd0) begin
                bom_left_next = bom_left_reg - 3'd1;
            end
            else if (f == FMT_UTF16LE || f == FMT_UTF16BE) begin
                if (pend_reg == 3'd0) begin
                    acc_next  = cp_t'(b);
                    pend_next = 3'd1;
                end
                else begin
                    pend_next = 3'd0;
                    acc_next  = '0;
                    lead_next = '0;
                    if (u[15:10] == 6'b110110) begin
                        // A lead after a lead: the first one was unpaired.
                        job.cp0_valid = lead_reg[10];
                        job.cp0       = REPL_CP;
                        lead_next     = {1'b1, u[9:0]};
                    end
                    else if (u[15:10] == 6'b110111) begin
                        job.cp0_valid = 1'b1;
                        job.cp0       = lead_reg[10] ? SUPP_BASE + {1'b0, lead_reg[9:0], u[9:0]}
                                                     : REPL_CP;
                    end
                    else if (lead_reg[10]) begin
                        job.cp0_valid = 1'b1;
                        job.cp0       = REPL_CP;
                        job.cp1_valid = 1'b1;
                        job.cp1       = cp_t'(u);
                    end
                    else begin
                        job.cp0_valid = 1'b1;
                        job.cp0       = cp_t'(u);
                    end
                end
            end
            else if (f == FMT_UTF32LE || f == FMT_UTF32BE) begin
                if (pend_reg >= 3'd3) begin
                    job.cp0_valid = 1'b1;
                    job.cp0       = acc32;
                    acc_next      = '0;
                    pend_next     = 3'd0;
                end
                else begin
                    acc_next  = acc32;
                    pend_next = pend_reg + 3'd1;
                end
            end
            else begin
                if (pend_reg != 3'd0) begin
                    // Continuation bytes are taken as they are, low six bits only.
                    acc_next  = acc8;
                    pend_next = pend_reg - 3'd1;
                    if (pend_reg == 3'd1) begin
                        job.cp0_valid = 1'b1;
                        job.cp0       = acc8;
                    end
                end
                else if (b < 8'h80) begin
                    job.cp0_valid = 1'b1;
                    job.cp0       = cp_t'(b);
                end
                else if (b inside {[8'hC0:8'hDF]}) begin
                    acc_next  = cp_t'(b[4:0]);
                    pend_next = 3'd1;
                end
                else if (b inside {[8'hE0:8'hEF]}) begin
                    acc_next  = cp_t'(b[3:0]);
                    pend_next = 3'd2;
                end
                else if (b inside {[8'hF0:8'hF7]}) begin
                    acc_next  = cp_t'(b[2:0]);
                    pend_next = 3'd3;
                end
                else begin
                    job.cp0_valid = 1'b1;
                    job.cp0       = REPL_CP;
                end
            end
        end

        if (cfg.we) begin
            case (cfg.index)
                REG_SOURCE_FORMAT: begin
                    source_format_next = cfg.data;
                    if (!bom_sent_reg) begin
                        bom_left_next = bom_len(cfg.data);
                    end
                end
                REG_TARGET_FORMAT: target_format_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            source_format_reg <= FMT_UTF8;
            target_format_reg <= FMT_UTF8;
            acc_reg           <= '0;
            pend_reg          <= '0;
            lead_reg          <= '0;
            bom_left_reg      <= bom_len(FMT_UTF8);
            bom_sent_reg      <= 1'b0;
        end
        else begin
            source_format_reg <= source_format_next;
            target_format_reg <= target_format_next;
            acc_reg           <= acc_next;
            pend_reg          <= pend_next;
            lead_reg          <= lead_next;
            bom_left_reg      <= bom_left_next;
            bom_sent_reg      <= bom_sent_next;
        end
    end

    assign in_ready            = !queue_full;
    assign push.valid          = accept && (job.bom || job.cp0_valid);
    assign push.job            = job;
    assign target_format       = target_format_reg;
    assign status.bom_sent     = bom_sent_reg;
    assign status.unit_pending = (pend_reg != 3'd0);
    assign status.lead_pending = lead_reg[10];

endmodule

// ----- rtl/core/utft_queue.sv -----
// ----------------------------------------------------------------------------
// UTF transcoder job queue
// Small first-in first-out buffer of jobs between the front end and the
// byte emitter, so that either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module utft_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  utft_pkg::queue_push_t push,
    input  logic                  pop,
    output logic                  full,
    output utft_pkg::queue_head_t head
);
    import utft_pkg::*;

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
    endfunction

    always_comb begin
        do_push     = push.valid && !full;
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.job;
        end
    end

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = entry_reg[rd_ptr_reg];

endmodule

// ----- rtl/core/utft_back.sv -----
// ----------------------------------------------------------------------------
// UTF transcoder byte emitter
// Walks the job at the head of the queue, BOM first and then each code
// point, and puts one target byte per cycle into the output register unless out_ready stalls it.
// ----------------------------------------------------------------------------
module utft_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  utft_pkg::queue_head_t head,
    input  logic [2:0]            target_format,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output utft_pkg::out_item_t   out_data
);
    import utft_pkg::*;

    typedef enum logic [1:0] {
        SEG_BOM,
        SEG_CP0,
        SEG_CP1
    } seg_t;

    seg_t       seg_reg, seg_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg, out_item_next;

    seg_t       cur_seg;
    seg_t       nxt_seg;
    cp_t        cur_cp;
    logic [2:0] cur_len;
    logic [7:0] cur_byte;
    logic       seg_done;
    logic       has_next;
    logic       load;

    always_comb begin
        // A fresh job rests on the BOM segment; skip it if the job has none.
        cur_seg = (seg_reg == SEG_BOM && !head.job.bom) ? SEG_CP0 : seg_reg;
        cur_cp  = (cur_seg == SEG_CP1) ? head.job.cp1 : head.job.cp0;

        case (cur_seg)
            SEG_BOM: begin
                cur_len  = bom_len(target_format);
                cur_byte = bom_byte(target_format, idx_reg);
                has_next = head.job.cp0_valid;
                nxt_seg  = SEG_CP0;
            end
            SEG_CP0: begin
                cur_len  = enc_len(target_format, cur_cp);
                cur_byte = enc_byte(target_format, cur_cp, idx_reg);
                has_next = head.job.cp1_valid;
                nxt_seg  = SEG_CP1;
            end
            default: begin
                cur_len  = enc_len(target_format, cur_cp);
                cur_byte = enc_byte(target_format, cur_cp, idx_reg);
                has_next = 1'b0;
                nxt_seg  = SEG_BOM;
            end
        endcase

        seg_done = ({1'b0, idx_reg} == cur_len - 3'd1);
        load     = head.valid && (!out_valid_reg || out_ready);
        pop      = load && seg_done && !has_next;

        seg_next       = seg_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (load) begin
            out_valid_next             = 1'b1;
            out_item_next.out_byte     = cur_byte;
            out_item_next.last_of_run  = seg_done && !has_next;
            if (seg_done) begin
                idx_next = 2'd0;
                seg_next = has_next ? nxt_seg : SEG_BOM;
            end
            else begin
                idx_next = idx_reg + 2'd1;
            end
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seg_reg       <= SEG_BOM;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else begin
            seg_reg       <= seg_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// ----- rtl/core/utf_transcoder.sv -----
// ----------------------------------------------------------------------------
// UTF transcoder
// Byte-stream converter between UTF-8, UTF-16 and UTF-32 in either byte order.
// ----------------------------------------------------------------------------
// The front end takes one source byte per cycle while the job queue is not full,
// updates the decoder state in that same cycle and hands any finished code
// points to a two-entry job queue. The byte emitter drains the queue at one
// target byte per cycle while out_ready is high. A code point yields one to
// four bytes, a job carries up to two code points, and the first job of a
// stream also carries the target BOM. Bytes that only fill a partial unit
// yield no code point. The emitter's single output byte per cycle sets the
// sustained rate; the job queue lets a new input be taken while a byte waits.
// Format registers should be written only while the block is idle.
module utf_transcoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  utft_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output utft_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [utft_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [utft_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import utft_pkg::*;

    cfg_write_t    cfg;
    queue_push_t   push;
    queue_head_t   head;
    front_status_t status;
    logic          queue_full;
    logic          pop;
    logic [2:0]    target_format;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    utft_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .cfg           (cfg),
        .queue_full    (queue_full),
        .push          (push),
        .target_format (target_format),
        .status        (status)
    );

    utft_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    utft_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .target_format (target_format),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data)
    );

    // A stream end leaves the decoder back at stream start.
    a_stream_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.stream_end) |=>
            (!status.bom_sent && !status.unit_pending && !status.lead_pending))
        else $error("decoder state not cleared after stream end");

    // The emitter only retires a job that is actually in the queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("job popped from an empty queue");

    // A transaction that is not the last of its run is followed at once by the next byte.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_of_run) |=> out_valid)
        else $error("output run broken before its last byte");

    // A job is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !queue_full)
        else $error("job pushed into a full queue");

endmodule

// ----- bench/utf_transcoder_test.sv -----
// ----------------------------------------------------------------------------
// UTF transcoder regression
// Drives byte streams through the transcoder and predicts every output byte
// with a behavioral decoder and encoder kept inside the bench. Directed
// streams cover the field extremes and the surrogate and BOM corner cases;
// random streams then run through random source and target format pairs while
// the sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module utf_transcoder_test;
    import utft_pkg::*;

    localparam int          RANDOM_ITEMS  = 420;
    localparam int          SETTLE_CYCLES = 24;
    localparam logic [20:0] REPLACEMENT   = 21'h00FFFD;

    // Up to four bytes of one code point or one BOM; octets[0] goes first.
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] octets;
    } byte_group_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Predicted transcoder state.
    logic [2:0]  src_format;
    logic [2:0]  tgt_format;
    logic [31:0] partial_code;
    logic [2:0]  bytes_owed;
    logic [10:0] held_lead;
    logic [2:0]  src_bom_left;
    logic        stream_open;

    logic [7:0]  run_bytes[$];
    out_item_t   expected_bytes[$];
    out_item_t   expected_head;
    in_item_t    stream_items[$];
    int          error_count = 0;
    int          burst_left  = 0;

    logic [15:0] stall_pattern = 16'hFFFF;
    int          stall_pos     = 0;
    int          stall_window  = 0;

    utf_transcoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [2:0] active_format(input logic [2:0] f);
        return (f > FMT_UTF32BE) ? FMT_UTF8 : f;
    endfunction

    function automatic logic [2:0] bom_length(input logic [2:0] f);
        case (active_format(f))
            FMT_UTF8_BOM:             return 3'd3;
            FMT_UTF16LE, FMT_UTF16BE: return 3'd2;
            FMT_UTF32LE, FMT_UTF32BE: return 3'd4;
            default:                  return 3'd0;
        endcase
    endfunction

    function automatic byte_group_t bom_group(input logic [2:0] f);
        byte_group_t g;
        g       = '0;
        g.count = bom_length(f);
        case (active_format(f))
            FMT_UTF8_BOM: g.octets = {8'h00, 8'hBF, 8'hBB, 8'hEF};
            FMT_UTF16LE:  g.octets = {16'h0000, 8'hFE, 8'hFF};
            FMT_UTF16BE:  g.octets = {16'h0000, 8'hFF, 8'hFE};
            FMT_UTF32LE:  g.octets = {8'h00, 8'h00, 8'hFE, 8'hFF};
            FMT_UTF32BE:  g.octets = {8'hFF, 8'hFE, 8'h00, 8'h00};
            default:      g.octets = '0;
        endcase
        return g;
    endfunction

    function automatic byte_group_t encode_code_point(input logic [2:0] f, input logic [20:0] cp);
        byte_group_t g;
        logic [15:0] hi_unit;
        logic [15:0] lo_unit;
        logic [19:0] offset;
        g       = '0;
        hi_unit = '0;
        lo_unit = '0;
        offset  = 20'(cp - 21'h010000);
        case (active_format(f))
            FMT_UTF16LE, FMT_UTF16BE:
            begin
                g.count = 3'd2;
                if (cp < 21'h010000)
                begin
                    hi_unit = cp[15:0];
                end
                else if (cp > 21'h10FFFF)
                begin
                    hi_unit = REPLACEMENT[15:0];
                end
                else
                begin
                    hi_unit = 16'hD800 | {6'd0, offset[19:10]};
                    lo_unit = 16'hDC00 | {6'd0, offset[9:0]};
                    g.count = 3'd4;
                end
                if (active_format(f) == FMT_UTF16BE)
                begin
                    g.octets = {lo_unit[7:0], lo_unit[15:8], hi_unit[7:0], hi_unit[15:8]};
                end
                else
                begin
                    g.octets = {lo_unit[15:8], lo_unit[7:0], hi_unit[15:8], hi_unit[7:0]};
                end
            end
            FMT_UTF32LE:
            begin
                g.count  = 3'd4;
                g.octets = {11'd0, cp};
            end
            FMT_UTF32BE:
            begin
                g.count  = 3'd4;
                g.octets = {cp[7:0], cp[15:8], {3'd0, cp[20:16]}, 8'h00};
            end
            default:
            begin
                if (cp <= 21'h00007F)
                begin
                    g.count     = 3'd1;
                    g.octets[0] = {1'b0, cp[6:0]};
                end
                else if (cp <= 21'h0007FF)
                begin
                    g.count     = 3'd2;
                    g.octets[0] = {3'b110, cp[10:6]};
                    g.octets[1] = {2'b10, cp[5:0]};
                end
                else if (cp <= 21'h00FFFF)
                begin
                    g.count     = 3'd3;
                    g.octets[0] = {4'b1110, cp[15:12]};
                    g.octets[1] = {2'b10, cp[11:6]};
                    g.octets[2] = {2'b10, cp[5:0]};
                end
                else
                begin
                    g.count     = 3'd4;
                    g.octets[0] = {5'b11110, cp[20:18]};
                    g.octets[1] = {2'b10, cp[17:12]};
                    g.octets[2] = {2'b10, cp[11:6]};
                    g.octets[3] = {2'b10, cp[5:0]};
                end
            end
        endcase
        return g;
    endfunction

    function automatic void queue_group(input byte_group_t g);
        for (int i = 0; i < int'(g.count); i++)
        begin
            run_bytes.push_back(g.octets[i]);
        end
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        queue_group(encode_code_point(tgt_format, cp));
    endfunction

    function automatic void restart_stream();
        partial_code = '0;
        bytes_owed   = '0;
        held_lead    = '0;
        src_bom_left = bom_length(src_format);
        stream_open  = 1'b0;
    endfunction

    function automatic void reset_model();
        src_format = FMT_UTF8;
        tgt_format = FMT_UTF8;
        restart_stream();
    endfunction

    // Works out the output bytes of one accepted input transaction.
    function automatic void transcode_byte(input in_item_t item);
        logic [7:0]  b;
        logic [15:0] unit;
        logic [2:0]  fmt;
        b   = item.data_byte;
        fmt = active_format(src_format);
        run_bytes.delete();
        if (!stream_open)
        begin
            queue_group(bom_group(tgt_format));
            stream_open = 1'b1;
        end
        if (item.stream_end)
        begin
            restart_stream();
        end
        else if (src_bom_left != 0)
        begin
            src_bom_left = src_bom_left - 3'd1;
        end
        else if (fmt == FMT_UTF16LE || fmt == FMT_UTF16BE)
        begin
            if (bytes_owed == 0)
            begin
                partial_code = {24'd0, b};
                bytes_owed   = 3'd1;
            end
            else
            begin
                bytes_owed   = 3'd0;
                unit         = (fmt == FMT_UTF16BE) ? {partial_code[7:0], b}
                                                    : {b, partial_code[7:0]};
                partial_code = '0;
                if (unit >= 16'hD800 && unit <= 16'hDBFF)
                begin
                    if (held_lead[10])
                    begin
                        emit_code_point(REPLACEMENT);
                    end
                    held_lead = {1'b1, unit[9:0]};
                end
                else if (unit >= 16'hDC00 && unit <= 16'hDFFF)
                begin
                    if (held_lead[10])
                    begin
                        emit_code_point(21'h010000 + {1'b0, held_lead[9:0], unit[9:0]});
                    end
                    else
                    begin
                        emit_code_point(REPLACEMENT);
                    end
                    held_lead = '0;
                end
                else
                begin
                    if (held_lead[10])
                    begin
                        emit_code_point(REPLACEMENT);
                    end
                    held_lead = '0;
                    emit_code_point({5'd0, unit});
                end
            end
        end
        else if (fmt == FMT_UTF32LE || fmt == FMT_UTF32BE)
        begin
            if (fmt == FMT_UTF32BE)
            begin
                partial_code = {partial_code[23:0], b};
            end
            else
            begin
                partial_code = partial_code | ({24'd0, b} << (8 * int'(bytes_owed[1:0])));
            end
            bytes_owed = bytes_owed + 3'd1;
            if (bytes_owed >= 3'd4)
            begin
                emit_code_point(partial_code[20:0]);
                partial_code = '0;
                bytes_owed   = '0;
            end
        end
        else
        begin
            // Continuation bytes are taken on trust; only their low six bits count.
            if (bytes_owed != 0)
            begin
                partial_code = {11'd0, partial_code[14:0], b[5:0]};
                bytes_owed   = bytes_owed - 3'd1;
                if (bytes_owed == 0)
                begin
                    emit_code_point(partial_code[20:0]);
                end
            end
            else if (b < 8'h80)
            begin
                emit_code_point({13'd0, b});
            end
            else if (b >= 8'hC0 && b < 8'hE0)
            begin
                partial_code = {27'd0, b[4:0]};
                bytes_owed   = 3'd1;
            end
            else if (b >= 8'hE0 && b < 8'hF0)
            begin
                partial_code = {28'd0, b[3:0]};
                bytes_owed   = 3'd2;
            end
            else if (b >= 8'hF0 && b < 8'hF8)
            begin
                partial_code = {29'd0, b[2:0]};
                bytes_owed   = 3'd3;
            end
            else
            begin
                emit_code_point(REPLACEMENT);
            end
        end
        for (int i = 0; i < run_bytes.size(); i++)
        begin
            expected_bytes.push_back(out_item_t'{out_byte: run_bytes[i],
                                                 last_of_run: (i == run_bytes.size() - 1)});
        end
    endfunction

    // Prediction and checking share one process so that an input and an output
    // transaction on the same edge are always handled in the same order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                transcode_byte(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual %02h last %0b",
                             $time, out_data.out_byte, out_data.last_of_run);
                    error_count++;
                end
                else
                begin
                    expected_head = expected_bytes.pop_front();
                    if (out_data.out_byte !== expected_head.out_byte)
                    begin
                        $display("%0t: out_byte expected %02h, actual %02h",
                                 $time, expected_head.out_byte, out_data.out_byte);
                        error_count++;
                    end
                    if (out_data.last_of_run !== expected_head.last_of_run)
                    begin
                        $display("%0t: last_of_run expected %0b, actual %0b",
                                 $time, expected_head.last_of_run, out_data.last_of_run);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver stalls follow a rotating pattern that is redrawn every window;
    // about one window in four has no stalls at all.
    always @(negedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_window  = $urandom_range(20, 120);
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        stall_window--;
        stall_pos = (stall_pos + 1) % 13;
        out_ready <= stall_pattern[stall_pos] | (stall_pos == 0);
    end

    task automatic send_item(input in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 8);
            gap        = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_staged();
        foreach (stream_items[i])
        begin
            send_item(stream_items[i]);
        end
        stream_items.delete();
    endtask

    // Holds the sender off until every expected byte has arrived, then lets
    // any byte that only filled a partial unit work its way through.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [2:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        if (idx == REG_SOURCE_FORMAT)
        begin
            src_format = value;
            if (!stream_open)
            begin
                src_bom_left = bom_length(value);
            end
        end
        else
        begin
            tgt_format = value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void stage_byte(input logic [7:0] b);
        stream_items.push_back(in_item_t'{stream_end: 1'b0, data_byte: b});
    endfunction

    function automatic void stage_end();
        stream_items.push_back(in_item_t'{stream_end: 1'b1, data_byte: 8'($urandom)});
    endfunction

    function automatic void stage_group(input byte_group_t g);
        for (int i = 0; i < int'(g.count); i++)
        begin
            stage_byte(g.octets[i]);
        end
    endfunction

    // The source BOM is dropped unchecked, so now and then it carries garbage.
    function automatic void stage_bom(input logic [2:0] f);
        byte_group_t g;
        g = bom_group(f);
        if ($urandom_range(0, 3) == 0)
        begin
            g.octets = $urandom;
        end
        stage_group(g);
    endfunction

    // Mostly well-formed code points in the source format, mixed with noise
    // units, malformed units and streams cut off in the middle of a code point.
    function automatic void build_stream(input logic [2:0] f, input int units, input bit with_bom);
        logic [2:0]  fmt;
        byte_group_t g;
        logic [31:0] word;
        int          kind;
        int          unit_bytes;
        fmt        = active_format(f);
        unit_bytes = (fmt == FMT_UTF16LE || fmt == FMT_UTF16BE) ? 2 :
                     (fmt == FMT_UTF32LE || fmt == FMT_UTF32BE) ? 4 : 1;
        if (with_bom)
        begin
            stage_bom(f);
        end
        for (int n = 0; n < units; n++)
        begin
            kind = $urandom_range(0, 19);
            case ($urandom_range(0, 7))
                0, 7: word = $urandom_range(0, 'h7F);
                1:    word = $urandom_range('h80, 'h7FF);
                2:    word = $urandom_range('h800, 'hFFFF);
                3:    word = $urandom_range('h10000, 'h10FFFF);
                4:    word = $urandom_range('hD800, 'hDFFF);
                5:    word = $urandom_range('h110000, 'h1FFFFF);
                default:
                begin
                    case ($urandom_range(0, 7))
                        0:       word = 'h0;
                        1:       word = 'h7F;
                        2:       word = 'h80;
                        3:       word = 'h7FF;
                        4:       word = 'h800;
                        5:       word = 'hFFFF;
                        6:       word = 'h10000;
                        default: word = 'h10FFFF;
                    endcase
                end
            endcase
            if (kind == 2)
            begin
                word = (unit_bytes == 2) ? $urandom_range('hD800, 'hDFFF) : $urandom;
            end
            if (fmt == FMT_UTF32LE)
            begin
                g.count  = 3'd4;
                g.octets = word;
            end
            else if (fmt == FMT_UTF32BE)
            begin
                g.count  = 3'd4;
                g.octets = {word[7:0], word[15:8], word[23:16], word[31:24]};
            end
            else
            begin
                g = encode_code_point(f, word[20:0]);
            end
            if (kind == 2 && unit_bytes == 1)
            begin
                g.count     = 3'd1;
                g.octets[0] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range('h80, 'hBF))
                                                          : 8'($urandom_range('hF8, 'hFF));
            end
            if (kind == 0)
            begin
                g.count  = 3'(unit_bytes);
                g.octets = $urandom;
            end
            if (kind == 1)
            begin
                g.count = 3'($urandom_range(0, int'(g.count) - 1));
            end
            stage_group(g);
            if (kind == 1)
            begin
                stage_end();
                stage_bom(f);
            end
        end
    endfunction

    task automatic test_utf8_edges();
        // Reset formats: UTF-8 in and out.
        stage_byte(8'h00);
        stage_byte(8'h7F);
        stage_byte(8'hF7);
        stage_byte(8'hBF);
        stage_byte(8'hBF);
        stage_byte(8'hBF);
        stage_byte(8'hFF);
        stage_byte(8'hED);
        stage_byte(8'hA0);
        stage_byte(8'h80);
        send_staged();
        settle();
    endtask

    task automatic test_utf16_surrogates();
        stage_end();
        send_staged();
        settle();
        write_reg(REG_SOURCE_FORMAT, FMT_UTF16BE);
        write_reg(REG_TARGET_FORMAT, FMT_UTF32BE);
        // BOM, a proper pair, a lone trail, a lead followed by a plain unit,
        // then a dangling half unit closed by stream end and an empty stream.
        stage_byte(8'hFE);
        stage_byte(8'hFF);
        stage_byte(8'hD8);
        stage_byte(8'h3D);
        stage_byte(8'hDE);
        stage_byte(8'h00);
        stage_byte(8'hDC);
        stage_byte(8'h00);
        stage_byte(8'hD8);
        stage_byte(8'h00);
        stage_byte(8'h00);
        stage_byte(8'h41);
        stage_byte(8'hD8);
        stage_end();
        stage_end();
        send_staged();
        settle();
    endtask

    task automatic test_random_streams();
        int         sent;
        int         phase;
        logic [2:0] src;
        logic [2:0] tgt;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // The first eight phases walk every code, unused ones included.
            if (phase < 8)
            begin
                src = 3'(phase);
                tgt = 3'(7 - phase);
            end
            else
            begin
                src = 3'($urandom_range(0, 7));
                tgt = 3'($urandom_range(0, 7));
            end
            stage_end();
            send_staged();
            settle();
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_SOURCE_FORMAT, src);
                write_reg(REG_TARGET_FORMAT, tgt);
            end
            else
            begin
                write_reg(REG_TARGET_FORMAT, tgt);
                write_reg(REG_SOURCE_FORMAT, src);
            end
            build_stream(src, $urandom_range(6, 14), 1'b1);
            sent += stream_items.size();
            send_staged();
            // Sometimes switch formats in the middle of a running stream.
            if ($urandom_range(0, 2) == 0)
            begin
                settle();
                if (bytes_owed == 0 && !held_lead[10])
                begin
                    case ($urandom_range(0, 3))
                        0:       src = FMT_UTF8;
                        1:       src = FMT_UTF16LE;
                        2:       src = FMT_UTF16BE;
                        default: src = FMT_UTF32BE;
                    endcase
                    write_reg(REG_SOURCE_FORMAT, src);
                end
                write_reg(REG_TARGET_FORMAT, 3'($urandom_range(0, 7)));
                build_stream(src_format, $urandom_range(4, 10), 1'b0);
                sent += stream_items.size();
                send_staged();
            end
            phase++;
        end
    endtask

    initial
    begin
        reset_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_utf8_edges();
        test_utf16_surrogates();
        test_random_streams();
        settle();
        if (error_count == 0)
        begin
            $display("utf_transcoder regression: pass");
        end
        else
        begin
            $display("utf_transcoder regression: fail");
        end
        $finish;
    end

    initial
    begin
        #6000000;
        $display("utf_transcoder regression: fail");
        $finish;
    end

endmodule

// ----- utf_transcoder.f -----
rtl/core/utft_pkg.sv
rtl/core/utft_front.sv
rtl/core/utft_queue.sv
rtl/core/utft_back.sv
rtl/core/utf_transcoder.sv
bench/utf_transcoder_test.sv
